>>> rtl/core/qrs_pkg.sv
package qrs_pkg;

  localparam int DW   = 32;          // coefficient and root width
  localparam int FW   = 16;          // fraction bits
  localparam int MW   = DW;          // magnitude width, holds 2^(DW-1)
  localparam int PW   = 2 * MW;      // product width
  localparam int SQW  = DW + 1;      // square root width
  localparam int RADW = 2 * SQW;     // radicand width, equals PW + 2
  localparam int RW   = SQW + 3;     // root remainder width
  localparam int NW   = SQW + 1;     // numerator magnitude width
  localparam int NSW  = NW + 1;      // signed numerator width
  localparam int QW   = NW + FW;     // dividend and quotient width
  localparam int DVW  = DW + 1;      // divisor width, 2*|a|
  localparam int WW   = DVW + QW;    // divider working word
  localparam int LAT  = 3 + SQW + 1 + QW + 1;

  localparam logic [QW-1:0] QHALF = QW'(1) << (DW - 1);

  typedef enum logic [1:0] {
    ST_REAL  = 2'd0,
    ST_CPLX  = 2'd1,
    ST_AZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic          azero;
    logic          an;
    logic          bn;
    logic          dneg;
    logic [MW-1:0] am;
    logic [MW-1:0] bm;
  } sq_side_t;

  typedef struct packed {
    logic           azero;
    logic           cplx;
    logic           neg0;
    logic           neg1;
    logic [DVW-1:0] d;
  } dv_side_t;

  // {saturated, value}
  function automatic logic [DW:0] clip(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] t;
    t = QW'(0) - q;
    if (neg) begin
      if (q > QHALF) return {1'b1, QHALF[DW-1:0]};
      return {1'b0, t[DW-1:0]};
    end
    if (q > QHALF - QW'(1)) return {1'b1, (QHALF[DW-1:0] - DW'(1))};
    return {1'b0, q[DW-1:0]};
  endfunction

endpackage

>>> rtl/core/qrs_sqrt_cell.sv
module qrs_sqrt_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  qrs_pkg::sq_side_t       in_side,
  input  logic [qrs_pkg::RADW-1:0] in_rad,
  input  logic [qrs_pkg::RW-1:0]  in_rem,
  input  logic [qrs_pkg::SQW-1:0] in_root,
  output logic                    out_vld,
  output qrs_pkg::sq_side_t       out_side,
  output logic [qrs_pkg::RADW-1:0] out_rad,
  output logic [qrs_pkg::RW-1:0]  out_rem,
  output logic [qrs_pkg::SQW-1:0] out_root
);
  import qrs_pkg::*;

  logic            vld_r;
  sq_side_t        side_r;
  logic [RADW-1:0] rad_r, rad_nxt;
  logic [RW-1:0]   rem_r, rem_nxt, rem_sh, trial;
  logic [SQW-1:0]  root_r, root_nxt;
  logic            ge;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh   = {in_rem[RW-3:0], in_rad[RADW-1 -: 2]};
    trial    = {1'b0, in_root, 2'b01};
    ge       = rem_sh >= trial;
    rem_nxt  = ge ? rem_sh - trial : rem_sh;
    root_nxt = {in_root[SQW-2:0], ge};
    rad_nxt  = {in_rad[RADW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= in_side;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;

endmodule

>>> rtl/core/qrs_div_cell.sv
module qrs_div_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  qrs_pkg::dv_side_t      in_side,
  input  logic [qrs_pkg::WW-1:0] in_w0,
  input  logic [qrs_pkg::WW-1:0] in_w1,
  output logic                   out_vld,
  output qrs_pkg::dv_side_t      out_side,
  output logic [qrs_pkg::WW-1:0] out_w0,
  output logic [qrs_pkg::WW-1:0] out_w1
);
  import qrs_pkg::*;

  logic          vld_r;
  dv_side_t      side_r;
  logic [WW-1:0] w0_r, w0_nxt, w1_r, w1_nxt;

  // word holds {remainder, dividend bits left, quotient bits so far}
  function automatic logic [WW-1:0] div_step(input logic [WW-1:0] w,
                                             input logic [DVW-1:0] d);
    logic [DVW:0] top, dif;
    logic         ge;
    top = w[WW-1 -: DVW+1];
    ge  = top >= {1'b0, d};
    dif = ge ? top - {1'b0, d} : top;
    return {dif[DVW-1:0], w[QW-2:0], ge};
  endfunction

  always_comb begin
    w0_nxt = div_step(in_w0, in_side.d);
    w1_nxt = div_step(in_w1, in_side.d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= in_side;
    w0_r   <= w0_nxt;
    w1_r   <= w1_nxt;
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_w0   = w0_r;
  assign out_w1   = w1_r;

endmodule

>>> rtl/core/quadratic_root_solver.sv
// Roots of a*x^2 + b*x + c for signed Q16.16 coefficients. A word is taken on
// every cycle that start is high (busy is always low), and its result appears
// on the out_ ports for one cycle with out_valid after the pipeline: registers
// for operand split, the two 32x32 products and the discriminant, a 33-cell
// square root chain resolving one root bit per cell, a numerator register, a
// 50-cell divider chain producing one quotient bit per cell on two lanes, and
// the saturating output register. The receiver cannot stall, so results must
// be taken as they come. Status 0 means real roots, 1 a complex pair, 2 a zero
// a coefficient with all parts zero.
module quadratic_root_solver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [qrs_pkg::DW-1:0] in_coef_a,
  input  logic signed [qrs_pkg::DW-1:0] in_coef_b,
  input  logic signed [qrs_pkg::DW-1:0] in_coef_c,
  output logic                          out_valid,
  output logic signed [qrs_pkg::DW-1:0] out_root1_re,
  output logic signed [qrs_pkg::DW-1:0] out_root1_im,
  output logic signed [qrs_pkg::DW-1:0] out_root2_re,
  output logic signed [qrs_pkg::DW-1:0] out_root2_im,
  output logic [1:0]                    out_status,
  output logic                          out_saturated
);
  import qrs_pkg::*;

  // split
  logic          s1_vld_r;
  logic          s1_an_r, s1_bn_r, s1_cn_r, s1_azero_r;
  logic [MW-1:0] s1_am_r, s1_bm_r, s1_cm_r;
  logic [DW-1:0] ua, ub, uc;
  // products
  logic          s2_vld_r, s2_add_r;
  logic          s2_an_r, s2_bn_r, s2_azero_r;
  logic [MW-1:0] s2_am_r, s2_bm_r;
  logic [PW-1:0] s2_bb_r, s2_ac_r, bb_nxt, ac_nxt;
  // discriminant
  logic            s3_vld_r;
  sq_side_t        s3_side_r, s3_side_nxt;
  logic [RADW-1:0] s3_rad_r, rad_nxt, bbx, ac4x;
  logic            bb_ge;
  // numerators
  logic          nm_vld_r;
  dv_side_t      nm_side_r, nm_side_nxt;
  logic [WW-1:0] nm_w0_r, nm_w1_r, w0_nxt, w1_nxt;
  logic [NSW-1:0] bs, sx, n1, n2, n1m, n2m;
  logic [NW-1:0]  m0, m1;
  // output
  logic          o_vld_r;
  logic [DW-1:0] o_re1_r, o_im1_r, o_re2_r, o_im2_r;
  logic [DW-1:0] re1_nxt, im1_nxt, re2_nxt, im2_nxt;
  logic [1:0]    o_st_r;
  status_t       st_nxt;
  logic          o_sat_r, sat_nxt;
  logic [DW:0]   c0, c1, c1n;

  logic            sq_vld  [0:SQW];
  sq_side_t        sq_side [0:SQW];
  logic [RADW-1:0] sq_rad  [0:SQW];
  logic [RW-1:0]   sq_rem  [0:SQW];
  logic [SQW-1:0]  sq_root [0:SQW];

  logic            dv_vld  [0:QW];
  dv_side_t        dv_side [0:QW];
  logic [WW-1:0]   dv_w0   [0:QW];
  logic [WW-1:0]   dv_w1   [0:QW];

  assign busy = 1'b0;

  assign ua = in_coef_a;
  assign ub = in_coef_b;
  assign uc = in_coef_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      nm_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      nm_vld_r <= sq_vld[SQW];
      o_vld_r  <= dv_vld[QW];
    end
  end

  // stage 1: sign and magnitude; the most negative value maps to 2^(DW-1)
  always_ff @(posedge clk) begin
    s1_an_r    <= ua[DW-1];
    s1_bn_r    <= ub[DW-1];
    s1_cn_r    <= uc[DW-1];
    s1_am_r    <= ua[DW-1] ? ~ua + 1'b1 : ua;
    s1_bm_r    <= ub[DW-1] ? ~ub + 1'b1 : ub;
    s1_cm_r    <= uc[DW-1] ? ~uc + 1'b1 : uc;
    s1_azero_r <= ua == '0;
  end

  // stage 2: b*b and a*c
  assign bb_nxt = s1_bm_r * s1_bm_r;
  assign ac_nxt = s1_am_r * s1_cm_r;

  always_ff @(posedge clk) begin
    s2_bb_r    <= bb_nxt;
    s2_ac_r    <= ac_nxt;
    s2_add_r   <= (s1_an_r != s1_cn_r) && (s1_cm_r != '0);
    s2_an_r    <= s1_an_r;
    s2_bn_r    <= s1_bn_r;
    s2_am_r    <= s1_am_r;
    s2_bm_r    <= s1_bm_r;
    s2_azero_r <= s1_azero_r;
  end

  // stage 3: |delta| and its sign
  always_comb begin
    bbx   = {2'b00, s2_bb_r};
    ac4x  = {s2_ac_r, 2'b00};
    bb_ge = bbx >= ac4x;
    if (s2_add_r) begin
      rad_nxt = bbx + ac4x;
    end else if (bb_ge) begin
      rad_nxt = bbx - ac4x;
    end else begin
      rad_nxt = ac4x - bbx;
    end
    s3_side_nxt.azero = s2_azero_r;
    s3_side_nxt.an    = s2_an_r;
    s3_side_nxt.bn    = s2_bn_r;
    s3_side_nxt.dneg  = !s2_add_r && !bb_ge;
    s3_side_nxt.am    = s2_am_r;
    s3_side_nxt.bm    = s2_bm_r;
  end

  always_ff @(posedge clk) begin
    s3_side_r <= s3_side_nxt;
    s3_rad_r  <= rad_nxt;
  end

  assign sq_vld[0]  = s3_vld_r;
  assign sq_side[0] = s3_side_r;
  assign sq_rad[0]  = s3_rad_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  genvar g;
  for (g = 0; g < SQW; g++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (sq_vld[g]),
      .in_side  (sq_side[g]),
      .in_rad   (sq_rad[g]),
      .in_rem   (sq_rem[g]),
      .in_root  (sq_root[g]),
      .out_vld  (sq_vld[g+1]),
      .out_side (sq_side[g+1]),
      .out_rad  (sq_rad[g+1]),
      .out_rem  (sq_rem[g+1]),
      .out_root (sq_root[g+1])
    );
  end

  // numerators: real -b+s, -b-s; complex -b and s (the second imaginary part
  // is the first negated)
  always_comb begin
    bs  = sq_side[SQW].bn ? NSW'(0) - NSW'(sq_side[SQW].bm) : NSW'(sq_side[SQW].bm);
    sx  = NSW'(sq_root[SQW]);
    n1  = sx - bs;
    n2  = NSW'(0) - sx - bs;
    n1m = n1[NSW-1] ? NSW'(0) - n1 : n1;
    n2m = n2[NSW-1] ? NSW'(0) - n2 : n2;
    nm_side_nxt.azero = sq_side[SQW].azero;
    nm_side_nxt.cplx  = sq_side[SQW].dneg;
    nm_side_nxt.d     = {sq_side[SQW].am, 1'b0};
    if (sq_side[SQW].dneg) begin
      m0 = NW'(sq_side[SQW].bm);
      m1 = NW'(sq_root[SQW]);
      nm_side_nxt.neg0 = !sq_side[SQW].bn ^ sq_side[SQW].an;
      nm_side_nxt.neg1 = sq_side[SQW].an;
    end else begin
      m0 = n1m[NW-1:0];
      m1 = n2m[NW-1:0];
      nm_side_nxt.neg0 = n1[NSW-1] ^ sq_side[SQW].an;
      nm_side_nxt.neg1 = n2[NSW-1] ^ sq_side[SQW].an;
    end
    w0_nxt = {{DVW{1'b0}}, m0, {FW{1'b0}}};
    w1_nxt = {{DVW{1'b0}}, m1, {FW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    nm_side_r <= nm_side_nxt;
    nm_w0_r   <= w0_nxt;
    nm_w1_r   <= w1_nxt;
  end

  assign dv_vld[0]  = nm_vld_r;
  assign dv_side[0] = nm_side_r;
  assign dv_w0[0]   = nm_w0_r;
  assign dv_w1[0]   = nm_w1_r;

  for (g = 0; g < QW; g++) begin : g_dv
    qrs_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (dv_vld[g]),
      .in_side  (dv_side[g]),
      .in_w0    (dv_w0[g]),
      .in_w1    (dv_w1[g]),
      .out_vld  (dv_vld[g+1]),
      .out_side (dv_side[g+1]),
      .out_w0   (dv_w0[g+1]),
      .out_w1   (dv_w1[g+1])
    );
  end

  // saturate and apply signs
  always_comb begin
    c0  = clip(dv_w0[QW][QW-1:0], dv_side[QW].neg0);
    c1  = clip(dv_w1[QW][QW-1:0], dv_side[QW].neg1);
    c1n = clip(dv_w1[QW][QW-1:0], !dv_side[QW].neg1);
    if (dv_side[QW].azero) begin
      st_nxt  = ST_AZERO;
      re1_nxt = '0;
      im1_nxt = '0;
      re2_nxt = '0;
      im2_nxt = '0;
      sat_nxt = 1'b0;
    end else if (dv_side[QW].cplx) begin
      st_nxt  = ST_CPLX;
      re1_nxt = c0[DW-1:0];
      im1_nxt = c1[DW-1:0];
      re2_nxt = c0[DW-1:0];
      im2_nxt = c1n[DW-1:0];
      sat_nxt = c0[DW] | c1[DW] | c1n[DW];
    end else begin
      st_nxt  = ST_REAL;
      re1_nxt = c0[DW-1:0];
      im1_nxt = '0;
      re2_nxt = c1[DW-1:0];
      im2_nxt = '0;
      sat_nxt = c0[DW] | c1[DW];
    end
  end

  always_ff @(posedge clk) begin
    o_re1_r <= re1_nxt;
    o_im1_r <= im1_nxt;
    o_re2_r <= re2_nxt;
    o_im2_r <= im2_nxt;
    o_st_r  <= st_nxt;
    o_sat_r <= sat_nxt;
  end

  assign out_valid     = o_vld_r;
  assign out_root1_re  = o_re1_r;
  assign out_root1_im  = o_im1_r;
  assign out_root2_re  = o_re2_r;
  assign out_root2_im  = o_im2_r;
  assign out_status    = o_st_r;
  assign out_saturated = o_sat_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("accepted word did not yield a result on time");

  a_azero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_AZERO |->
      out_root1_re == '0 && out_root1_im == '0 && out_root2_re == '0 &&
      out_root2_im == '0 && !out_saturated)
    else $error("zero a result not cleared");

  a_real: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_REAL |-> out_root1_im == '0 && out_root2_im == '0)
    else $error("real roots with imaginary part");

  a_cplx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CPLX |-> out_root1_re == out_root2_re)
    else $error("complex pair not conjugate");
`endif

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  typedef struct {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] c;
  } coef_word_t;

  typedef struct {
    logic signed [DW-1:0] r1_re;
    logic signed [DW-1:0] r1_im;
    logic signed [DW-1:0] r2_re;
    logic signed [DW-1:0] r2_im;
    status_t              status;
    logic                 sat;
  } roots_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [DW-1:0] in_coef_a = '0;
  logic signed [DW-1:0] in_coef_b = '0;
  logic signed [DW-1:0] in_coef_c = '0;
  logic                 out_valid;
  logic signed [DW-1:0] out_root1_re, out_root1_im, out_root2_re, out_root2_im;
  logic [1:0]           out_status;
  logic                 out_saturated;

  coef_word_t pending_coefs[$];
  roots_t     expected_roots[$];
  int         gap_pct = 10;
  int         errors = 0;
  int         n_checked = 0;
  int         n_status[3] = '{0, 0, 0};
  int         n_sat = 0;

  always #5 clk = ~clk;

  quadratic_root_solver u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid),
    .out_root1_re(out_root1_re), .out_root1_im(out_root1_im),
    .out_root2_re(out_root2_re), .out_root2_im(out_root2_im),
    .out_status(out_status), .out_saturated(out_saturated)
  );

  function automatic logic [63:0] int_sqrt(input logic [127:0] v);
    logic [63:0]  r;
    logic [127:0] t;
    r = '0;
    for (int k = 40; k >= 0; k--) begin
      t = 128'(r | (64'd1 << k));
      if (t * t <= v) r = t[63:0];
    end
    return r;
  endfunction

  // num in Q(F), divided by 2a, rounded toward zero, then clipped
  function automatic logic [DW-1:0] div_by_2a(input logic signed [127:0] num,
                                               input logic signed [127:0] a,
                                               inout logic sat);
    logic [127:0] nmag, amag, q;
    logic         neg;
    nmag = num < 0 ? -num : num;
    amag = a < 0 ? -a : a;
    neg  = (num < 0) != (a < 0);
    q    = (nmag << FW) / (amag << 1);
    if (neg) begin
      if (q > 128'(1) << (DW - 1)) begin
        sat = 1'b1;
        return {1'b1, {(DW-1){1'b0}}};
      end
      return DW'(-q);
    end
    if (q > (128'(1) << (DW - 1)) - 1) begin
      sat = 1'b1;
      return {1'b0, {(DW-1){1'b1}}};
    end
    return q[DW-1:0];
  endfunction

  function automatic roots_t solve_roots(input coef_word_t w);
    roots_t              r;
    logic signed [127:0] a, b, c, delta;
    logic signed [127:0] s;
    logic                sat;
    a = w.a; b = w.b; c = w.c;
    sat = 1'b0;
    r = '{default: '0, status: ST_AZERO};
    if (a == 0) return r;
    delta = b * b - 4 * a * c;
    if (delta >= 0) begin
      s = $signed({64'd0, int_sqrt(delta)});
      r.r1_re = div_by_2a(-b + s, a, sat);
      r.r2_re = div_by_2a(-b - s, a, sat);
      r.status = ST_REAL;
    end else begin
      s = $signed({64'd0, int_sqrt(-delta)});
      r.r1_re = div_by_2a(-b, a, sat);
      r.r1_im = div_by_2a(s, a, sat);
      r.r2_re = r.r1_re;
      r.r2_im = div_by_2a(-s, a, sat);
      r.status = ST_CPLX;
    end
    r.sat = sat;
    return r;
  endfunction

  // driver: one assignment per signal per edge
  always @(posedge clk) begin
    logic       take;
    coef_word_t w;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = !start || !busy;
      if (start && !busy)
        expected_roots.push_back(solve_roots('{in_coef_a, in_coef_b, in_coef_c}));
      if (take) begin
        if (pending_coefs.size() > 0 && $urandom_range(99) >= gap_pct) begin
          w = pending_coefs.pop_front();
          in_coef_a <= w.a;
          in_coef_b <= w.b;
          in_coef_c <= w.c;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string field, input logic [DW-1:0] exp_v,
                        input logic [DW-1:0] act_v);
    $display("%0t: %s expected %h actual %h", $time, field, exp_v, act_v);
    errors++;
  endtask

  // monitor: results cannot be held off, take one whenever out_valid is high
  always @(posedge clk) begin
    roots_t e;
    if (rst_n && out_valid) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual status %0d",
                 $time, out_status);
        errors++;
      end else begin
        e = expected_roots.pop_front();
        n_checked++;
        n_status[e.status]++;
        if (e.sat) n_sat++;
        if (out_root1_re !== e.r1_re) report("root1_re", e.r1_re, out_root1_re);
        if (out_root1_im !== e.r1_im) report("root1_im", e.r1_im, out_root1_im);
        if (out_root2_re !== e.r2_re) report("root2_re", e.r2_re, out_root2_re);
        if (out_root2_im !== e.r2_im) report("root2_im", e.r2_im, out_root2_im);
        if (out_status !== e.status) report("status", e.status, out_status);
        if (out_saturated !== e.sat) report("saturated", e.sat, out_saturated);
      end
    end
  end

  function automatic logic signed [DW-1:0] rand_coef();
    case ($urandom_range(5))
      0, 1: return $signed($urandom());
      2:    return DW'($signed($urandom_range(65535, 0) - 32768) <<< FW); // whole
      3:    return DW'($signed(20'($urandom())));                         // small
      4:    return $urandom_range(1) ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      default: return DW'($signed(24'($urandom())));
    endcase
  endfunction

  task automatic add(input logic signed [DW-1:0] a, b, c);
    pending_coefs.push_back('{a, b, c});
  endtask

  task automatic drain();
    while (pending_coefs.size() > 0 || start || expected_roots.size() > 0)
      @(posedge clk);
  endtask

  localparam logic signed [DW-1:0] ONE  = 1 <<< FW;
  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  initial begin
    coef_word_t w;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero a, extremes, zero discriminant, complex pair, saturation
    add(0, 5 * ONE, 3 * ONE);
    add(0, MINV, MAXV);
    add(ONE, -2 * ONE, ONE);
    add(ONE, 0, ONE);
    add(ONE, -3 * ONE, 2 * ONE);
    add(-ONE, ONE, 6 * ONE);
    add(1, MAXV, 0);
    add(1, MINV, 0);
    add(-1, MAXV, MAXV);
    add(MINV, MINV, MINV);
    add(MAXV, MAXV, MAXV);
    add(MINV, MAXV, MINV);
    add(MAXV, MINV, MAXV);
    add(MAXV, 0, MINV);
    add(MINV, 0, MINV);
    add(ONE, 0, 0);
    add(-1, -1, -1);
    add(1, 0, -1);
    add(2 * ONE, 4 * ONE, 3 * ONE);
    add(-ONE, 0, -ONE);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = phase == 0 ? 10 : phase == 1 ? 87 : 0;
      for (int n = 0; n < 145; n++) begin
        w = '{rand_coef(), rand_coef(), rand_coef()};
        if ($urandom_range(19) == 0) w.a = 0;
        if ($urandom_range(9) == 0) w.c = 0;
        pending_coefs.push_back(w);
      end
      drain();
    end

    repeat (LAT + 10) @(posedge clk);
    $display("Checked %0d result words: %0d real, %0d complex, %0d zero-a, %0d saturated",
             n_checked, n_status[0], n_status[1], n_status[2], n_sat);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule
